// ===== hw/rtl/bir_pkg.sv =====
package bir_pkg;

  // shared multiply-add unit operand widths
  localparam int MUL_A_W = 26;   // signed: 25-bit scale or 25-bit lerp delta
  localparam int MUL_B_W = 17;   // signed: 13-bit odd coordinate or 16-bit weight
  localparam int MAC_W   = 43;
  localparam int ADD_W   = 24;   // lerp base, shifted up by 16 before the add

  // Q16 and Q32 constants
  localparam logic [36:0] HALF_PIXEL_Q16 = 37'd32768;
  localparam logic [40:0] ROUND_Q32      = 41'd2147483648;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_COLS  = 3'd0;
  localparam logic [2:0] CFG_SRC_ROWS  = 3'd1;
  localparam logic [2:0] CFG_CHAN_CNT  = 3'd2;
  localparam logic [2:0] CFG_HSCALE    = 3'd3;
  localparam logic [2:0] CFG_VSCALE    = 3'd4;

  // request to the shared multiply-add unit: res = mul_a * mul_b + (addend << 16)
  typedef struct packed {
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [ADD_W-1:0]          addend;
  } mac_req_t;

endpackage

// ===== hw/rtl/bir_mac.sv =====
module bir_mac (
  input  bir_pkg::mac_req_t                 req,
  output logic signed [bir_pkg::MAC_W-1:0]  res
);

  logic signed [bir_pkg::MAC_W-1:0] prod;
  logic signed [bir_pkg::MAC_W-1:0] base;

  assign prod = req.mul_a * req.mul_b;
  assign base = $signed({3'b000, req.addend, 16'h0000});
  assign res  = prod + base;

endmodule

// ===== hw/rtl/bir_axis_map.sv =====
module bir_axis_map #(
  parameter int AXW = 8
) (
  input  logic [37:0]    prod,
  input  logic [AXW:0]   size,
  output logic [AXW-1:0] idx0,
  output logic [AXW-1:0] idx1,
  output logic [15:0]    wgt
);

  logic [36:0] half;
  logic [36:0] frac_coord;
  logic [20:0] idx;
  logic [AXW:0] last;
  logic [20:0] last_ext;
  logic        neg;
  logic        clip;
  logic [AXW:0] nxt;

  assign half       = prod[37:1];
  assign neg        = (half[36:15] == '0);
  assign frac_coord = half - bir_pkg::HALF_PIXEL_Q16;
  assign idx        = frac_coord[36:16];
  assign last       = size - (AXW+1)'(1);
  assign last_ext   = 21'(last);
  assign clip       = (idx >= last_ext);

  always_comb begin
    if (neg) begin
      idx0 = '0;
      wgt  = '0;
    end else if (clip) begin
      idx0 = last[AXW-1:0];
      wgt  = '0;
    end else begin
      idx0 = idx[AXW-1:0];
      wgt  = frac_coord[15:0];
    end
  end

  // neighbor clamps at the last column/row
  assign nxt  = {1'b0, idx0} + (AXW+1)'(1);
  assign idx1 = (nxt < size) ? nxt[AXW-1:0] : last[AXW-1:0];

endmodule

// ===== hw/rtl/bilinear_image_resize_top.sv =====
// Bilinear image scaler, 8-bit channels (1 to 4), half-pixel-center mapping.
//
// Request channel: start/busy. A request is taken at a rising edge with start
// high and busy low. in_op = 0 stores the pixel in_chan0..3 at (in_column,
// in_row) of the frame memory; writes outside the configured source size are
// dropped. A write leaves busy low. in_op = 1 asks for the destination
// pixel at (in_column, in_row).
// Result channel: out_valid pulses for one cycle with out_chan0..3. The
// receiver cannot stall; each result must be taken in its strobe cycle.
// A read: out_valid is high in the same cycle as busy drops, so the next read
// is taken only once the last result is out. The sequencer works around one
// shared multiply-add unit: the X/Y coordinate products, the Y clamp, four
// frame-memory reads on a single read port, and the blend steps (three lerps
// per channel, four channels).
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while no read is in flight.
// Reset: sequencer idles, registers take 256, 256, 1, 1.0, 1.0. The frame
// memory is not cleared; read only pixels that were written.
module bilinear_image_resize_top #(
  parameter int MAX_SOURCE_COLUMNS = 256,
  parameter int MAX_SOURCE_ROWS    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  input  logic [7:0]  in_chan0,
  input  logic [7:0]  in_chan1,
  input  logic [7:0]  in_chan2,
  input  logic [7:0]  in_chan3,
  // result channel
  output logic        out_valid,
  output logic [7:0]  out_chan0,
  output logic [7:0]  out_chan1,
  output logic [7:0]  out_chan2,
  output logic [7:0]  out_chan3,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  localparam int CB   = $clog2(MAX_SOURCE_COLUMNS);
  localparam int RB   = $clog2(MAX_SOURCE_ROWS);
  localparam int AXW  = (CB > RB) ? CB : RB;
  localparam int SZ_W = AXW + 1;
  localparam int AW   = CB + RB;
  localparam logic [12:0] MAX_C13 = 13'(MAX_SOURCE_COLUMNS);
  localparam logic [12:0] MAX_R13 = 13'(MAX_SOURCE_ROWS);
  localparam logic [2:0]  FETCH_LAST = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,    // X coordinate product
    S_MULY,    // X clamp, Y coordinate product
    S_MAPY,    // Y clamp
    S_FETCH,   // four neighbor reads
    S_BLEND    // lerp steps
  } state_t;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_BOT,
    PH_VERT
  } phase_t;

  // config registers
  logic [8:0]  img_cols_r;
  logic [8:0]  img_rows_r;
  logic [2:0]  chan_cnt_r;
  logic [24:0] hscale_r;
  logic [24:0] vscale_r;

  // sequencer
  state_t      state_r;
  phase_t      ph_r;
  logic [1:0]  ch_r;
  logic [2:0]  cnt_r;
  logic [11:0] col_r;
  logic [11:0] row_r;
  logic signed [bir_pkg::MAC_W-1:0] prod_r;
  logic [AXW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [15:0] wx_r, wy_r;
  logic [31:0] pix_r [4];
  logic [23:0] top_r;
  logic [23:0] bot_r;
  logic [7:0]  out_chan_r [4];
  logic        out_valid_r;

  // frame memory
  logic [31:0]   mem_r [2**AW];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic          mem_we;

  logic [12:0]     cols13, rows13;
  logic [SZ_W-1:0] cols_eff, rows_eff;
  logic            req_take;

  bir_pkg::mac_req_t mac_req;
  logic signed [bir_pkg::MAC_W-1:0] mac_res;
  logic [40:0] rnd;

  logic [AXW:0]   map_size;
  logic [AXW-1:0] map_i0, map_i1;
  logic [15:0]    map_w;

  logic [7:0]  byte_p, byte_q;
  logic [23:0] lerp_p, lerp_q;
  logic [15:0] lerp_w;

  // ---------------------------------------------------------------
  // config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_cols_r <= 9'd256;
      img_rows_r <= 9'd256;
      chan_cnt_r <= 3'd1;
      hscale_r   <= 25'd65536;
      vscale_r   <= 25'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bir_pkg::CFG_SRC_COLS: img_cols_r <= cfg_data[8:0];
        bir_pkg::CFG_SRC_ROWS: img_rows_r <= cfg_data[8:0];
        bir_pkg::CFG_CHAN_CNT: chan_cnt_r <= cfg_data[2:0];
        bir_pkg::CFG_HSCALE:   hscale_r   <= cfg_data;
        bir_pkg::CFG_VSCALE:   vscale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective source size: zero acts as 1, saturates at the memory size
  assign cols13 = (img_cols_r == '0) ? 13'd1 :
                  ({4'b0, img_cols_r} > MAX_C13) ? MAX_C13 : {4'b0, img_cols_r};
  assign rows13 = (img_rows_r == '0) ? 13'd1 :
                  ({4'b0, img_rows_r} > MAX_R13) ? MAX_R13 : {4'b0, img_rows_r};
  assign cols_eff = cols13[SZ_W-1:0];
  assign rows_eff = rows13[SZ_W-1:0];

  // ---------------------------------------------------------------
  // request intake and frame memory
  assign busy     = (state_r != S_IDLE);
  assign req_take = start && !busy;
  assign mem_we   = req_take && !in_op &&
                    ({1'b0, in_column} < cols13) && ({1'b0, in_row} < rows13);
  assign wr_addr  = {in_row[RB-1:0], in_column[CB-1:0]};

  assign rd_en = (state_r == S_FETCH) && (cnt_r != FETCH_LAST);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    rd_addr = {y0_r[RB-1:0], x0_r[CB-1:0]};
      2'd1:    rd_addr = {y0_r[RB-1:0], x1_r[CB-1:0]};
      2'd2:    rd_addr = {y1_r[RB-1:0], x0_r[CB-1:0]};
      default: rd_addr = {y1_r[RB-1:0], x1_r[CB-1:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= {in_chan3, in_chan2, in_chan1, in_chan0};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // shared multiply-add unit
  // lerp(p, q, w) = p*65536 + (q - p)*w, exact: Q16 for the row lerps, Q32 for the vertical one
  assign byte_p = (ph_r == PH_TOP) ? pix_r[0][{ch_r, 3'b000} +: 8]
                                   : pix_r[2][{ch_r, 3'b000} +: 8];
  assign byte_q = (ph_r == PH_TOP) ? pix_r[1][{ch_r, 3'b000} +: 8]
                                   : pix_r[3][{ch_r, 3'b000} +: 8];
  assign lerp_p = (ph_r == PH_VERT) ? top_r : {16'h0000, byte_p};
  assign lerp_q = (ph_r == PH_VERT) ? bot_r : {16'h0000, byte_q};
  assign lerp_w = (ph_r == PH_VERT) ? wy_r : wx_r;

  always_comb begin
    case (state_r)
      S_MULX: begin
        mac_req.mul_a  = $signed({1'b0, hscale_r});
        mac_req.mul_b  = $signed({4'b0000, col_r, 1'b1});
        mac_req.addend = '0;
      end
      S_MULY: begin
        mac_req.mul_a  = $signed({1'b0, vscale_r});
        mac_req.mul_b  = $signed({4'b0000, row_r, 1'b1});
        mac_req.addend = '0;
      end
      S_BLEND: begin
        mac_req.mul_a  = $signed({2'b00, lerp_q}) - $signed({2'b00, lerp_p});
        mac_req.mul_b  = $signed({1'b0, lerp_w});
        mac_req.addend = lerp_p;
      end
      default: begin
        mac_req.mul_a  = '0;
        mac_req.mul_b  = '0;
        mac_req.addend = '0;
      end
    endcase
  end

  bir_mac u_mac (
    .req (mac_req),
    .res (mac_res)
  );

  // Q32 to byte, nearest with ties up
  assign rnd = mac_res[40:0] + bir_pkg::ROUND_Q32;

  // coordinate clamp, shared by both axes
  assign map_size = (state_r == S_MULY) ? cols_eff : rows_eff;

  bir_axis_map #(
    .AXW (AXW)
  ) u_axis_map (
    .prod (prod_r[37:0]),
    .size (map_size),
    .idx0 (map_i0),
    .idx1 (map_i1),
    .wgt  (map_w)
  );

  // ---------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_TOP;
      ch_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req_take && in_op) begin
            col_r   <= in_column;
            row_r   <= in_row;
            state_r <= S_MULX;
          end
        end
        S_MULX: begin
          prod_r  <= mac_res;
          state_r <= S_MULY;
        end
        S_MULY: begin
          x0_r    <= map_i0;
          x1_r    <= map_i1;
          wx_r    <= map_w;
          prod_r  <= mac_res;
          state_r <= S_MAPY;
        end
        S_MAPY: begin
          y0_r    <= map_i0;
          y1_r    <= map_i1;
          wy_r    <= map_w;
          cnt_r   <= '0;
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          // read data is registered, so it lands in the cycle after its address
          if (cnt_r != '0) begin
            pix_r[cnt_r[1:0] - 2'd1] <= rd_data_r;
          end
          if (cnt_r == FETCH_LAST) begin
            ch_r    <= '0;
            ph_r    <= PH_TOP;
            state_r <= S_BLEND;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_BLEND: begin
          case (ph_r)
            PH_TOP: begin
              top_r <= mac_res[23:0];
              ph_r  <= PH_BOT;
            end
            PH_BOT: begin
              bot_r <= mac_res[23:0];
              ph_r  <= PH_VERT;
            end
            default: begin
              out_chan_r[ch_r] <= ({1'b0, ch_r} < chan_cnt_r) ? rnd[39:32] : 8'h00;
              ph_r <= PH_TOP;
              ch_r <= ch_r + 2'd1;
              if (ch_r == 2'd3) begin
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_chan0 = out_chan_r[0];
  assign out_chan1 = out_chan_r[1];
  assign out_chan2 = out_chan_r[2];
  assign out_chan3 = out_chan_r[3];

  // ---------------------------------------------------------------
  // assertions

  // a result only follows the last blend step
  a_out_after_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_BLEND && ph_r == PH_VERT && ch_r == 2'd3))
    else $error("result strobe without finished blend");

  // results are single-cycle strobes, never back to back
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // neighbor indexes stay inside the source image
  a_nbr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (({1'b0, x1_r} < cols_eff) && ({1'b0, y1_r} < rows_eff)))
    else $error("neighbor index outside source image");

  // clamped to the last column means no horizontal weight
  a_edge_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && ({1'b0, x0_r} + SZ_W'(1)) >= cols_eff) |-> (wx_r == '0))
    else $error("nonzero weight at last column");

endmodule
